FILE: sv/rtc_pkg.sv
// Shared types, constants and helper functions of the radix text converter.
// Depends on nothing; every other file of the block imports it.
package rtc_pkg;

   localparam int VALUE_WIDTH = 32;

   // Number of digits of the widest value in each output radix.
   localparam int DIGITS_2  = VALUE_WIDTH;
   localparam int DIGITS_8  = (VALUE_WIDTH + 2) / 3;
   localparam int DIGITS_16 = (VALUE_WIDTH + 3) / 4;
   localparam int DIGITS_10 = (VALUE_WIDTH * 30103) / 100000 + 1;

   // The digit buffer holds the BCD digits and any power-of-two digit string.
   localparam int BUF_W   = 4 * DIGITS_10;
   localparam int SHIFT_2  = BUF_W - VALUE_WIDTH;
   localparam int SHIFT_8  = BUF_W - 3 * DIGITS_8;
   localparam int SHIFT_16 = BUF_W - 4 * DIGITS_16;
   localparam int CNT_W    = $clog2(VALUE_WIDTH + 1);
   localparam int PROD_W   = VALUE_WIDTH + 5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [4:0] NO_DIGIT   = 5'd16;

   typedef enum logic [1:0] {
      BASE_2  = 2'd0,
      BASE_8  = 2'd1,
      BASE_10 = 2'd2,
      BASE_16 = 2'd3
   } base_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      base_type               dest;
      status_type             err;
   } job_type;

   function automatic logic [4:0] char_value(input logic [7:0] c);
      logic [4:0] d;
      d = NO_DIGIT;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         d = 5'(c - CHAR_ZERO);
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         d = 5'(c - CHAR_UPPER_A) + 5'd10;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         d = 5'(c - CHAR_LOWER_A) + 5'd10;
      end
      return d;
   endfunction

   function automatic logic [4:0] radix_value(input base_type b);
      logic [4:0] r;
      unique case (b)
         BASE_2:  r = 5'd2;
         BASE_8:  r = 5'd8;
         BASE_10: r = 5'd10;
         BASE_16: r = 5'd16;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CHAR_ZERO + 8'(d);
      end else begin
         c = CHAR_UPPER_A + 8'(d) - 8'd10;
      end
      return c;
   endfunction

endpackage

FILE: sv/radix_text_converter.sv
// Top level of the radix text converter: front end, job queue and back end.
// Depends on rtc_pkg, rtc_front, rtc_job_queue and rtc_back.
//
// Usage. Characters of a number are pushed on the req_ channel, most significant
// first, one transaction per character; req_last_char marks the final one, and
// req_dest_base is taken from that transaction. Each character is checked and
// folded into the value in the cycle it is accepted, so the request side takes
// one character per cycle while the job queue has room. A finished number moves
// through a two-entry queue to the back end, which prints it.
// Results leave on the rsp_ channel as a queue: one transaction per digit, most
// significant first, rsp_last_out on the final digit; an invalid digit or an
// overflow gives one transaction with the status and a zero character instead.
// A finished number is written into the queue; the back end takes it while
// idle, passes each suppressed leading zero in its skip state and registers
// digits from its emit state, or registers a status from its error state;
// for radix 10 a binary to BCD pass over every value bit comes first. Digits
// leave one per cycle while the receiver pops each one. The back end handles
// one number at a time. When the receiver stalls, the output register holds
// its result, the back end waits and the queue fills, after which req_full
// rises. Reset empties the queue and the output register and clears the value.
module radix_text_converter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_digit_char,
   input  logic [1:0] req_source_base,
   input  logic [1:0] req_dest_base,
   input  logic       req_last_char,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic [1:0] rsp_status,
   output logic       rsp_last_out
);
   import rtc_pkg::*;

   logic    job_push;
   job_type job_in;
   logic    job_full;
   logic    job_pop;
   logic    job_valid;
   job_type job_head;

   rtc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_digit_char  (req_digit_char),
      .req_source_base (req_source_base),
      .req_dest_base   (req_dest_base),
      .req_last_char   (req_last_char),
      .job_push        (job_push),
      .job_data        (job_in),
      .job_full        (job_full)
   );

   rtc_job_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .valid     (job_valid),
      .head      (job_head)
   );

   rtc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_head     (job_head),
      .job_pop      (job_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_char (rsp_out_char),
      .rsp_status   (rsp_status),
      .rsp_last_out (rsp_last_out)
   );

endmodule

FILE: sv/rtc_front.sv
// Front end: validates each character and accumulates the value of the number.
// Hands a finished number to the job queue. Depends on rtc_pkg.
module rtc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_digit_char,
   input  logic [1:0]           req_source_base,
   input  logic [1:0]           req_dest_base,
   input  logic                 req_last_char,
   output logic                 job_push,
   output rtc_pkg::job_type     job_data,
   input  logic                 job_full
);
   import rtc_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;
   status_type             err_ff;
   status_type             err_in;
   logic [4:0]             digit;
   logic [4:0]             radix;
   logic [PROD_W-1:0]      wide;
   logic [PROD_W-1:0]      prod;
   logic                   accept;

   assign req_full = job_full;
   assign accept   = req_push && !req_full;
   assign digit    = char_value(req_digit_char);
   assign radix    = radix_value(base_type'(req_source_base));
   assign wide     = PROD_W'(value_ff);

   always_comb begin
      unique case (base_type'(req_source_base))
         BASE_2:  prod = (wide << 1) + PROD_W'(digit);
         BASE_8:  prod = (wide << 3) + PROD_W'(digit);
         BASE_10: prod = (wide << 3) + (wide << 1) + PROD_W'(digit);
         BASE_16: prod = (wide << 4) + PROD_W'(digit);
      endcase
   end

   always_comb begin
      value_in = value_ff;
      err_in   = err_ff;
      if (err_ff == ST_OK) begin
         if (digit >= radix) begin
            err_in = ST_INVALID;
         end else if (prod[PROD_W-1:VALUE_WIDTH] != '0) begin
            err_in = ST_OVERFLOW;
         end else begin
            value_in = prod[VALUE_WIDTH-1:0];
         end
      end
   end

   assign job_push       = accept && req_last_char;
   assign job_data.value = value_in;
   assign job_data.dest  = base_type'(req_dest_base);
   assign job_data.err   = err_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         err_ff   <= ST_OK;
      end else if (accept) begin
         if (req_last_char) begin
            value_ff <= '0;
            err_ff   <= ST_OK;
         end else begin
            value_ff <= value_in;
            err_ff   <= err_in;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && accept && !req_last_char) |=> (err_ff == $past(err_ff)))
      else $error("A recorded error was overwritten within a number.");

   assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK && accept && !req_last_char) |=> $stable(value_ff))
      else $error("The accumulator moved after an error.");

   assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_char) |=> (value_ff == '0 && err_ff == ST_OK))
      else $error("State not cleared after the last character.");

endmodule

FILE: sv/rtc_job_queue.sv
// Short queue of finished numbers between the front end and the digit emitter.
// Depends on rtc_pkg.
module rtc_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rtc_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output rtc_pkg::job_type head
);
   import rtc_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push;
   logic              do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("Job queue count beyond its depth.");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("Job queue lost a transaction on push.");

endmodule

FILE: sv/rtc_back.sv
// Back end: converts a queued number to ASCII digits, most significant first,
// and holds each result in an output register. Depends on rtc_pkg.
module rtc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  rtc_pkg::job_type job_head,
   output logic             job_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_char,
   output logic [1:0]       rsp_status,
   output logic             rsp_last_out
);
   import rtc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DABBLE,
      S_SKIP,
      S_EMIT,
      S_ERROR
   } state_type;

   state_type              state_ff;
   base_type               dest_ff;
   status_type             err_ff;
   logic [BUF_W-1:0]       buf_ff;
   logic [VALUE_WIDTH-1:0] bin_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   out_valid_ff;
   logic [7:0]             out_char_ff;
   status_type             out_status_ff;
   logic                   out_last_ff;

   logic [3:0]             top_digit;
   logic [BUF_W-1:0]       shift_in;
   logic [BUF_W-1:0]       adjust;
   logic [BUF_W-1:0]       dabble_in;
   logic [BUF_W-1:0]       load_value;
   logic                   can_emit;
   logic                   emit_now;

   assign can_emit   = !out_valid_ff || rsp_pop;
   assign emit_now   = can_emit && (state_ff == S_EMIT || state_ff == S_ERROR);
   assign job_pop    = (state_ff == S_IDLE) && job_valid;
   assign load_value = BUF_W'(job_head.value);

   always_comb begin
      unique case (dest_ff)
         BASE_2: begin
            top_digit = {3'b000, buf_ff[BUF_W-1]};
            shift_in  = buf_ff << 1;
         end
         BASE_8: begin
            top_digit = {1'b0, buf_ff[BUF_W-1 -: 3]};
            shift_in  = buf_ff << 3;
         end
         BASE_10, BASE_16: begin
            top_digit = buf_ff[BUF_W-1 -: 4];
            shift_in  = buf_ff << 4;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < DIGITS_10; i++) begin
         if (buf_ff[4*i +: 4] >= 4'd5) begin
            adjust[4*i +: 4] = buf_ff[4*i +: 4] + 4'd3;
         end else begin
            adjust[4*i +: 4] = buf_ff[4*i +: 4];
         end
      end
      dabble_in = {adjust[BUF_W-2:0], bin_ff[VALUE_WIDTH-1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= emit_now || (out_valid_ff && !rsp_pop);
         unique case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  dest_ff <= job_head.dest;
                  err_ff  <= job_head.err;
                  if (job_head.err != ST_OK) begin
                     state_ff <= S_ERROR;
                  end else begin
                     unique case (job_head.dest)
                        BASE_2: begin
                           buf_ff   <= load_value << SHIFT_2;
                           cnt_ff   <= CNT_W'(DIGITS_2);
                           state_ff <= S_SKIP;
                        end
                        BASE_8: begin
                           buf_ff   <= load_value << SHIFT_8;
                           cnt_ff   <= CNT_W'(DIGITS_8);
                           state_ff <= S_SKIP;
                        end
                        BASE_16: begin
                           buf_ff   <= load_value << SHIFT_16;
                           cnt_ff   <= CNT_W'(DIGITS_16);
                           state_ff <= S_SKIP;
                        end
                        BASE_10: begin
                           buf_ff   <= '0;
                           bin_ff   <= job_head.value;
                           cnt_ff   <= CNT_W'(VALUE_WIDTH);
                           state_ff <= S_DABBLE;
                        end
                     endcase
                  end
               end
            end
            S_DABBLE: begin
               buf_ff <= dabble_in;
               bin_ff <= bin_ff << 1;
               if (cnt_ff == CNT_W'(1)) begin
                  cnt_ff   <= CNT_W'(DIGITS_10);
                  state_ff <= S_SKIP;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_SKIP: begin
               if (cnt_ff > CNT_W'(1) && top_digit == 4'd0) begin
                  buf_ff <= shift_in;
                  cnt_ff <= cnt_ff - 1'b1;
               end else begin
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (can_emit) begin
                  out_char_ff   <= digit_to_ascii(top_digit);
                  out_status_ff <= ST_OK;
                  out_last_ff   <= (cnt_ff == CNT_W'(1));
                  buf_ff        <= shift_in;
                  cnt_ff        <= cnt_ff - 1'b1;
                  if (cnt_ff == CNT_W'(1)) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_ERROR: begin
               if (can_emit) begin
                  out_char_ff   <= 8'd0;
                  out_status_ff <= err_ff;
                  out_last_ff   <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_last_out = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff != ST_OK) |-> (out_last_ff && out_char_ff == 8'd0))
      else $error("An error transaction must be a single zero character.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT || state_ff == S_SKIP) |-> (cnt_ff != '0))
      else $error("Digit count ran out while emitting.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DABBLE) |-> (dest_ff == BASE_10))
      else $error("Binary to BCD pass entered for a non-decimal radix.");

endmodule
